@@ rtl/core/scled_pkg.sv @@
// Shared types, scancodes and key tables of the scancode line editor.
package scled_pkg;

	localparam int DefaultLineCapacity = 128;
	localparam int KeyTableLen = 59;

	// Set 1 press codes
	localparam logic [7:0] SC_BACKSPACE = 8'h0E;
	localparam logic [7:0] SC_TAB       = 8'h0F;
	localparam logic [7:0] SC_ENTER     = 8'h1C;
	localparam logic [7:0] SC_CTRL      = 8'h1D;
	localparam logic [7:0] SC_LSHIFT    = 8'h2A;
	localparam logic [7:0] SC_RSHIFT    = 8'h36;
	localparam logic [7:0] SC_ALT       = 8'h38;
	localparam logic [7:0] SC_CAPS      = 8'h3A;
	localparam logic [7:0] SC_F1        = 8'h3B;
	localparam logic [7:0] SC_F2        = 8'h3C;
	localparam logic [7:0] SC_F3        = 8'h3D;
	localparam logic [7:0] SC_KEY_L     = 8'h26;
	localparam logic [7:0] SC_KEY_C     = 8'h2E;

	// Set 1 release codes
	localparam logic [7:0] SC_LSHIFT_UP = 8'hAA;
	localparam logic [7:0] SC_RSHIFT_UP = 8'hB6;
	localparam logic [7:0] SC_CTRL_UP   = 8'h9D;
	localparam logic [7:0] SC_ALT_UP    = 8'hB8;

	localparam logic [6:0] ASCII_TAB = 7'h09;
	localparam logic [6:0] ASCII_LF  = 7'h0A;

	typedef enum logic [1:0] {
		EDIT_NONE   = 2'd0,
		EDIT_APPEND = 2'd1,
		EDIT_DELETE = 2'd2,
		EDIT_CLEAR  = 2'd3
	} edit_kind_t;

	typedef enum logic [2:0] {
		CMD_NONE  = 3'd0,
		CMD_TERM1 = 3'd1,
		CMD_TERM2 = 3'd2,
		CMD_TERM3 = 3'd3,
		CMD_HALT  = 3'd4
	} cmd_t;

	typedef struct packed {
		logic       char_valid;
		logic [6:0] char_code;
		edit_kind_t edit_kind;
		cmd_t       command;
		logic       line_done;
		logic [7:0] line_length;
	} result_t;

	function automatic logic [6:0] plain_key(input logic [5:0] idx);
		logic [6:0] c;
		unique case (idx)
			6'h02: c = 7'h31; 6'h03: c = 7'h32; 6'h04: c = 7'h33; 6'h05: c = 7'h34;
			6'h06: c = 7'h35; 6'h07: c = 7'h36; 6'h08: c = 7'h37; 6'h09: c = 7'h38;
			6'h0A: c = 7'h39; 6'h0B: c = 7'h30; 6'h0C: c = 7'h2D; 6'h0D: c = 7'h3D;
			6'h10: c = 7'h71; 6'h11: c = 7'h77; 6'h12: c = 7'h65; 6'h13: c = 7'h72;
			6'h14: c = 7'h74; 6'h15: c = 7'h79; 6'h16: c = 7'h75; 6'h17: c = 7'h69;
			6'h18: c = 7'h6F; 6'h19: c = 7'h70; 6'h1A: c = 7'h5B; 6'h1B: c = 7'h5D;
			6'h1E: c = 7'h61; 6'h1F: c = 7'h73; 6'h20: c = 7'h64; 6'h21: c = 7'h66;
			6'h22: c = 7'h67; 6'h23: c = 7'h68; 6'h24: c = 7'h6A; 6'h25: c = 7'h6B;
			6'h26: c = 7'h6C; 6'h27: c = 7'h3B; 6'h28: c = 7'h27; 6'h29: c = 7'h60;
			6'h2B: c = 7'h5C; 6'h2C: c = 7'h7A; 6'h2D: c = 7'h78; 6'h2E: c = 7'h63;
			6'h2F: c = 7'h76; 6'h30: c = 7'h62; 6'h31: c = 7'h6E; 6'h32: c = 7'h6D;
			6'h33: c = 7'h2C; 6'h34: c = 7'h2E; 6'h35: c = 7'h2F; 6'h37: c = 7'h2A;
			6'h39: c = 7'h20;
			default: c = 7'h00;
		endcase
		return c;
	endfunction

	function automatic logic [6:0] shift_key(input logic [5:0] idx);
		logic [6:0] p;
		logic [6:0] c;
		p = plain_key(idx);
		unique case (idx)
			6'h02: c = 7'h21; 6'h03: c = 7'h40; 6'h04: c = 7'h23; 6'h05: c = 7'h24;
			6'h06: c = 7'h25; 6'h07: c = 7'h5E; 6'h08: c = 7'h26; 6'h09: c = 7'h2A;
			6'h0A: c = 7'h28; 6'h0B: c = 7'h29; 6'h0C: c = 7'h5F; 6'h0D: c = 7'h2B;
			6'h1A: c = 7'h7B; 6'h1B: c = 7'h7D; 6'h27: c = 7'h3A; 6'h28: c = 7'h22;
			6'h29: c = 7'h7E; 6'h2B: c = 7'h7C; 6'h33: c = 7'h3C; 6'h34: c = 7'h3E;
			6'h35: c = 7'h3F;
			default: begin
				// letters shift to upper case, the rest keep their plain entry
				if (p >= 7'h61 && p <= 7'h7A)
					c = p - 7'h20;
				else
					c = p;
			end
		endcase
		return c;
	endfunction

endpackage

@@ rtl/core/scled_keymap.sv @@
// Press code to ASCII lookup under shift and caps lock.
module scled_keymap
	import scled_pkg::*;
(
	input  logic [6:0] code,
	input  logic       shift,
	input  logic       caps,
	output logic [6:0] ascii
);

	logic [6:0] base;

	always_comb begin
		if (code >= 7'(KeyTableLen))
			base = 7'h00;
		else if (shift)
			base = shift_key(code[5:0]);
		else
			base = plain_key(code[5:0]);
	end

	// caps lock swaps letter case, so shift plus caps gives lower case
	always_comb begin
		if (caps && base >= 7'h61 && base <= 7'h7A)
			ascii = base - 7'h20;
		else if (caps && base >= 7'h41 && base <= 7'h5A)
			ascii = base + 7'h20;
		else
			ascii = base;
	end

endmodule

@@ rtl/core/scled_editor.sv @@
// Modifier and line length state with the per-byte edit decision.
module scled_editor
	import scled_pkg::*;
#(
	parameter int LINE_CAPACITY = DefaultLineCapacity
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       advance,
	input  logic [7:0] scan_byte,
	output result_t    result
);

	localparam int FillW = $clog2(LINE_CAPACITY + 1);
	localparam logic [FillW-1:0] Capacity = FillW'(LINE_CAPACITY);
	localparam logic [FillW-1:0] CharLimit = FillW'(LINE_CAPACITY - 1);

	logic             shift_q, caps_q, ctrl_q, alt_q;
	logic             shift_d, caps_d, ctrl_d, alt_d;
	logic [FillW-1:0] fill_q, fill_d;
	logic [6:0]       ascii;

	scled_keymap u_keymap (
		.code  (scan_byte[6:0]),
		.shift (shift_q),
		.caps  (caps_q),
		.ascii (ascii)
	);

	always_comb begin
		shift_d = shift_q;
		caps_d  = caps_q;
		ctrl_d  = ctrl_q;
		alt_d   = alt_q;
		fill_d  = fill_q;
		result.char_valid = 1'b0;
		result.char_code  = 7'h00;
		result.edit_kind  = EDIT_NONE;
		result.command    = CMD_NONE;
		result.line_done  = 1'b0;
		if (scan_byte[7]) begin
			if (scan_byte == SC_LSHIFT_UP || scan_byte == SC_RSHIFT_UP)
				shift_d = 1'b0;
			else if (scan_byte == SC_CTRL_UP)
				ctrl_d = 1'b0;
			else if (scan_byte == SC_ALT_UP)
				alt_d = 1'b0;
		end else begin
			unique case (scan_byte)
				SC_BACKSPACE: begin
					if (fill_q != '0) begin
						fill_d = fill_q - 1'b1;
						result.edit_kind = EDIT_DELETE;
					end
				end
				SC_TAB, SC_ENTER: begin
					if (fill_q < Capacity) begin
						fill_d = fill_q + 1'b1;
						result.char_valid = 1'b1;
						result.edit_kind  = EDIT_APPEND;
						result.char_code  = (scan_byte == SC_TAB) ? ASCII_TAB : ASCII_LF;
						result.line_done  = (scan_byte == SC_ENTER);
					end
				end
				SC_CAPS: caps_d = !caps_q;
				SC_LSHIFT, SC_RSHIFT: shift_d = 1'b1;
				SC_ALT: alt_d = 1'b1;
				SC_CTRL: ctrl_d = 1'b1;
				SC_F1: if (alt_q) result.command = CMD_TERM1;
				SC_F2: if (alt_q) result.command = CMD_TERM2;
				SC_F3: if (alt_q) result.command = CMD_TERM3;
				default: begin
					if (scan_byte == SC_KEY_L && ctrl_q) begin
						ctrl_d = 1'b0;
						fill_d = '0;
						result.edit_kind = EDIT_CLEAR;
					end else if (scan_byte == SC_KEY_C && ctrl_q) begin
						ctrl_d = 1'b0;
						result.command = CMD_HALT;
					end else if (ascii != 7'h00 && fill_q < CharLimit) begin
						// plain characters leave one slot for tab or enter
						fill_d = fill_q + 1'b1;
						result.char_valid = 1'b1;
						result.edit_kind  = EDIT_APPEND;
						result.char_code  = ascii;
					end
				end
			endcase
		end
		result.line_length = 8'(fill_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q <= 1'b0;
			caps_q  <= 1'b0;
			ctrl_q  <= 1'b0;
			alt_q   <= 1'b0;
			fill_q  <= '0;
		end else if (advance) begin
			shift_q <= shift_d;
			caps_q  <= caps_d;
			ctrl_q  <= ctrl_d;
			alt_q   <= alt_d;
			fill_q  <= fill_d;
		end
	end

endmodule

@@ rtl/core/scancode_line_editor.sv @@
// Top level of the scancode line editor: input register, editor, result register.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+---------------------------------------
//   in      | input     | in_valid, in_stall  | scan_byte
//   out     | output    | out_valid, out_stall| char_valid, char_code, edit_kind,
//           |           |                     | command, line_done, line_length
//
// One transaction in per cycle while in_stall is low, one result per transaction:
// the byte is held in the input register, decoded and applied to the modifier and
// line length state in one pass, and the result lands in the output register.
// Reset clears the modifiers, caps lock and the line length.
// A stalled result holds in the output register; the input register still
// takes a byte, and in_stall rises only when both registers are full.
module scancode_line_editor
	import scled_pkg::*;
#(
	parameter int LINE_CAPACITY = DefaultLineCapacity
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] scan_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       char_valid,
	output logic [6:0] char_code,
	output logic [1:0] edit_kind,
	output logic [2:0] command,
	output logic       line_done,
	output logic [7:0] line_length
);

	logic       valid_s1, valid_s2;
	logic [7:0] scan_s1;
	result_t    result_d, result_s2;
	logic       open_s2, advance_s1, take_in;

	assign open_s2    = !valid_s2 || !out_stall;
	assign advance_s1 = valid_s1 && open_s2;
	assign in_stall   = valid_s1 && !open_s2;
	assign take_in    = in_valid && !in_stall;

	scled_editor #(
		.LINE_CAPACITY (LINE_CAPACITY)
	) u_editor (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance_s1),
		.scan_byte (scan_s1),
		.result    (result_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (take_in)
				valid_s1 <= 1'b1;
			else if (advance_s1)
				valid_s1 <= 1'b0;
			if (open_s2)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in)
			scan_s1 <= scan_byte;
		if (advance_s1)
			result_s2 <= result_d;
	end

	assign out_valid   = valid_s2;
	assign char_valid  = result_s2.char_valid;
	assign char_code   = result_s2.char_code;
	assign edit_kind   = result_s2.edit_kind;
	assign command     = result_s2.command;
	assign line_done   = result_s2.line_done;
	assign line_length = result_s2.line_length;

	a_append_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && char_valid |-> edit_kind == EDIT_APPEND)
		else $error("appended character without append edit");

	a_done_is_lf: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && line_done |-> char_valid && char_code == ASCII_LF)
		else $error("line done without newline");

	a_cmd_no_edit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && command != CMD_NONE |-> edit_kind == EDIT_NONE && !char_valid)
		else $error("command together with an edit");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid && out_stall)
		else $error("input stalled while the output side can move");

endmodule
